### design/cfa_pkg.sv
// Shared types, constants and lookup functions of the CFA false-color renderer.
`default_nettype none
package cfa_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BITS_W   = 5;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned FULL_W   = SAMPLE_W + 1;
  localparam int unsigned NUM_W    = 25;
  localparam int unsigned RECIP_W  = 25;
  localparam int unsigned RECIP_SH = 25;
  localparam int unsigned PROD_W   = NUM_W + RECIP_W;
  localparam int unsigned PIX_W    = 8;
  localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(SAMPLE_W);
  localparam logic [PIX_W-1:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_BITS    = 8'd0,
    REG_LITTLE_ENDIAN = 8'd1,
    REG_BAYER_PATTERN = 8'd2,
    REG_QUAD_BAYER    = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PAT_RGGB = 2'd0,
    PAT_GRBG = 2'd1,
    PAT_GBRG = 2'd2,
    PAT_BGGR = 2'd3
  } bayer_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic              little_endian;
    bayer_e            pattern;
    logic              quad;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    chan_e            site;
  } s1_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] quot;
    chan_e            site;
  } s2_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] prod;
    logic [PIX_W-1:0] quot;
    chan_e            site;
  } s3_t;

  // floor(2^25 / (2 * (2^bits - 1)))
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [BITS_W-1:0] bits);
    logic [RECIP_W-1:0] r;
    case (bits)
      5'd1:    r = 25'd16777216;
      5'd2:    r = 25'd5592405;
      5'd3:    r = 25'd2396745;
      5'd4:    r = 25'd1118481;
      5'd5:    r = 25'd541200;
      5'd6:    r = 25'd266305;
      5'd7:    r = 25'd132104;
      5'd8:    r = 25'd65793;
      5'd9:    r = 25'd32832;
      5'd10:   r = 25'd16400;
      5'd11:   r = 25'd8196;
      5'd12:   r = 25'd4097;
      5'd13:   r = 25'd2048;
      5'd14:   r = 25'd1024;
      5'd15:   r = 25'd512;
      default: r = 25'd256;
    endcase
    return r;
  endfunction

  function automatic logic [FULL_W-1:0] full_scale(input logic [BITS_W-1:0] bits);
    logic [FULL_W-1:0] one;
    one = FULL_W'(1);
    return (one << bits) - one;
  endfunction

  function automatic chan_e site_lookup(input bayer_e pat, input logic oy, input logic ox);
    chan_e ch;
    case (pat)
      PAT_RGGB: ch = oy ? (ox ? CH_BLUE : CH_GREEN) : (ox ? CH_GREEN : CH_RED);
      PAT_GRBG: ch = oy ? (ox ? CH_GREEN : CH_BLUE) : (ox ? CH_RED : CH_GREEN);
      PAT_GBRG: ch = oy ? (ox ? CH_GREEN : CH_RED) : (ox ? CH_BLUE : CH_GREEN);
      PAT_BGGR: ch = oy ? (ox ? CH_RED : CH_GREEN) : (ox ? CH_GREEN : CH_BLUE);
      default:  ch = CH_GREEN;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### design/cfa_cfg_regs.sv
// Configuration register file with bit-depth saturation.
`default_nettype none
module cfa_cfg_regs
  import cfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VALID_BITS: begin
          if (cfg_data_i == '0 || cfg_data_i > BITS_MAX) begin
            cfg_d.bits = BITS_MAX;
          end else begin
            cfg_d.bits = cfg_data_i;
          end
        end
        REG_LITTLE_ENDIAN: cfg_d.little_endian = cfg_data_i[0];
        REG_BAYER_PATTERN: cfg_d.pattern = bayer_e'(cfg_data_i[1:0]);
        REG_QUAD_BAYER:    cfg_d.quad = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits          <= BITS_MAX;
      cfg_q.little_endian <= 1'b1;
      cfg_q.pattern       <= PAT_RGGB;
      cfg_q.quad          <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### design/cfa_unpack.sv
// Stage 1: word assembly, masking, scaling numerator and color site.
`default_nettype none
module cfa_unpack
  import cfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire cfg_t               cfg_i,
  input  wire logic               valid_i,
  input  wire logic [BYTE_W-1:0]  first_byte_i,
  input  wire logic [BYTE_W-1:0]  second_byte_i,
  input  wire logic [COORD_W-1:0] column_i,
  input  wire logic [COORD_W-1:0] row_i,
  output logic                    valid_o,
  output s1_t                     s1_o
);

  logic [FULL_W-1:0]   full;
  logic [SAMPLE_W-1:0] word;
  logic [SAMPLE_W-1:0] sample;
  logic                ox, oy;
  logic                valid_q;
  s1_t                 s1_d, s1_q;

  always_comb begin
    full   = full_scale(cfg_i.bits);
    word   = cfg_i.little_endian ? {second_byte_i, first_byte_i}
                                 : {first_byte_i, second_byte_i};
    sample = word & full[SAMPLE_W-1:0];
    ox     = cfg_i.quad ? column_i[1] : column_i[0];
    oy     = cfg_i.quad ? row_i[1] : row_i[0];
    s1_d.num  = ({sample, 9'b0} - {8'b0, sample, 1'b0}) + NUM_W'(full);
    s1_d.site = site_lookup(cfg_i.pattern, oy, ox);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule
`default_nettype wire

### design/cfa_scale.sv
// Stages 2 and 3: reciprocal multiply for the quotient estimate and back-multiply.
`default_nettype none
module cfa_scale
  import cfa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire cfg_t cfg_i,
  input  wire logic valid_i,
  input  wire s1_t  s1_i,
  output logic      valid_o,
  output s3_t       s3_o
);

  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] divisor;
  logic              s2_valid_q, s3_valid_q;
  s2_t               s2_d, s2_q;
  s3_t               s3_d, s3_q;

  always_comb begin
    prod      = PROD_W'(s1_i.num) * PROD_W'(recip_lookup(cfg_i.bits));
    s2_d.num  = s1_i.num;
    s2_d.quot = prod[RECIP_SH +: PIX_W];
    s2_d.site = s1_i.site;
  end

  always_comb begin
    divisor   = full_scale(cfg_i.bits) << 1;
    s3_d.num  = s2_q.num;
    s3_d.prod = NUM_W'(s2_q.quot) * NUM_W'(divisor);
    s3_d.quot = s2_q.quot;
    s3_d.site = s2_q.site;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign s3_o    = s3_q;

endmodule
`default_nettype wire

### design/cfa_false_color_renderer.sv
// Top level of the CFA false-color renderer: pipeline control, correction and output stage.
// The block turns one stored raw sample per transaction into one RGBA pixel. It takes a
// transaction in every cycle unless the output stalls and passes each result through
// the pipeline registers in order: unpack and numerator, reciprocal multiply, back-multiply,
// then quotient correction and channel routing into the output register. The scaled value is
// floor((510*v + M) / (2*M)) with M = 2^valid_bits - 1, exact for every sample. All stages
// advance together; a stalled result holds the whole pipeline and in_stall_o rises in the
// same cycle. Configuration registers are written through the plain write port and must
// only change while no transaction is in flight.
`default_nettype none
module cfa_false_color_renderer
  import cfa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     first_byte_i,
  input  wire logic [BYTE_W-1:0]     second_byte_i,
  input  wire logic [COORD_W-1:0]    column_i,
  input  wire logic [COORD_W-1:0]    row_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           red_o,
  output logic [PIX_W-1:0]           green_o,
  output logic [PIX_W-1:0]           blue_o,
  output logic [PIX_W-1:0]           alpha_o
);

  cfg_t              cfg;
  logic              en;
  logic              s1_valid, s3_valid;
  s1_t               s1;
  s3_t               s3;
  logic [NUM_W-1:0]  rem;
  logic [FULL_W-1:0] divisor;
  logic [PIX_W:0]    quot_fix;
  logic [PIX_W-1:0]  pix;
  logic              out_valid_q;
  logic [PIX_W-1:0]  red_d, green_d, blue_d;
  logic [PIX_W-1:0]  red_q, green_q, blue_q;

  assign en = !(out_valid_q && out_stall_i);

  cfa_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cfa_unpack u_unpack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .cfg_i         (cfg),
    .valid_i       (in_valid_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .valid_o       (s1_valid),
    .s1_o          (s1)
  );

  cfa_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s3_valid),
    .s3_o    (s3)
  );

  always_comb begin
    divisor  = full_scale(cfg.bits) << 1;
    rem      = s3.num - s3.prod;
    quot_fix = {1'b0, s3.quot} + ((rem >= NUM_W'(divisor)) ? (PIX_W+1)'(1) : '0);
    pix      = quot_fix[PIX_W] ? ALPHA_OPAQUE : quot_fix[PIX_W-1:0];
    red_d    = (s3.site == CH_RED)   ? pix : '0;
    green_d  = (s3.site == CH_GREEN) ? pix : '0;
    blue_d   = (s3.site == CH_BLUE)  ? pix : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = ALPHA_OPAQUE;

  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid)
    else $error("accepted transaction did not enter stage 1");

  a_quot_within_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid |-> (rem < NUM_W'({divisor, 1'b0})))
    else $error("quotient estimate off by more than one");

  a_single_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({red_o != '0, green_o != '0, blue_o != '0}) <= 1))
    else $error("more than one color channel carries the sample");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(s3_valid)))
    else $error("pipeline advanced under output stall");

endmodule
`default_nettype wire
